@@ rtl/sost_pkg.sv @@
// Shared constants, types and helper functions for the sequence-ordered segment table.
package sost_pkg;

    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 32;
    localparam int HDL_W    = 16;
    localparam int RANK_W   = 5;
    localparam int STAT_W   = 3;
    localparam int CMD_W    = 2;
    localparam int ENTRY_W  = KEY_W + HDL_W;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REPLACED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

    typedef struct packed {
        logic [HDL_W-1:0] handle;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HDL_W-1:0]  handle;
        logic [RANK_W-1:0] rank;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    function automatic logic serial_greater(input logic [KEY_W-1:0] a,
                                            input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[KEY_W-1];
    endfunction

    function automatic logic [RANK_W-1:0] to_rank(input logic [IDX_W-1:0] idx);
        logic [RANK_W+IDX_W-1:0] wide;
        wide = {{RANK_W{1'b0}}, idx};
        return wide[RANK_W-1:0];
    endfunction

endpackage

@@ rtl/sost_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sost_ctrl.sv @@
// Walk engine that searches, inserts into and removes from the sorted entry RAM.
module sost_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  sost_pkg::req_t              req,
    output sost_pkg::ram_req_t          ram_req,
    input  logic [sost_pkg::ENTRY_W-1:0] ram_rdata,
    input  logic                        out_free,
    output logic                        res_valid,
    output sost_pkg::result_t           res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [sost_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sost_pkg::CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                          rvalid_reg, rvalid_next;
    logic                          shift_reg, shift_next;
    logic [sost_pkg::IDX_W-1:0]    proc_idx_reg, proc_idx_next;
    sost_pkg::req_t                req_reg, req_next;
    sost_pkg::entry_t              carry_reg, carry_next;
    sost_pkg::result_t             res_reg, res_next;
    sost_pkg::entry_t              rd_entry;
    sost_pkg::entry_t              new_entry;
    logic                          issue;
    logic                          is_insert;
    logic                          is_remove;
    logic                          key_gt;
    logic                          key_eq;

    assign rd_entry  = sost_pkg::entry_t'(ram_rdata);
    assign new_entry = '{handle: req_reg.handle, key: req_reg.key};
    assign is_insert = (req_reg.cmd == sost_pkg::CMD_INSERT);
    assign is_remove = (req_reg.cmd == sost_pkg::CMD_REMOVE);
    assign key_gt    = sost_pkg::serial_greater(rd_entry.key, req_reg.key);
    assign key_eq    = (rd_entry.key == req_reg.key);
    assign issue     = (rd_idx_reg < cnt_reg);
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN) && out_free;
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        rvalid_next   = 1'b0;
        shift_next    = shift_reg;
        proc_idx_next = proc_idx_reg;
        req_next      = req_reg;
        carry_next    = carry_reg;
        res_next      = res_reg;
        ram_req       = '{we: 1'b0, waddr: proc_idx_reg, wdata: new_entry,
                          raddr: rd_idx_reg[sost_pkg::IDX_W-1:0]};

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next    = req;
                    rd_idx_next = '0;
                    shift_next  = 1'b0;
                    if (req.cmd == sost_pkg::CMD_INSERT
                        && cnt_reg == sost_pkg::CNT_W'(sost_pkg::DEPTH)) begin
                        res_next   = '{status: sost_pkg::STAT_FULL, handle: '0, rank: '0};
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (issue) begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    rvalid_next   = 1'b1;
                    proc_idx_next = rd_idx_reg[sost_pkg::IDX_W-1:0];
                end
                if (rvalid_reg) begin
                    if (is_insert) begin
                        if (shift_reg) begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = carry_reg;
                            carry_next    = rd_entry;
                        end else if (key_gt) begin
                            ram_req.we = 1'b1;
                            carry_next = rd_entry;
                            shift_next = 1'b1;
                            res_next   = '{status: sost_pkg::STAT_INSERTED, handle: '0,
                                           rank: sost_pkg::to_rank(proc_idx_reg)};
                        end else if (key_eq) begin
                            ram_req.we  = 1'b1;
                            res_next    = '{status: sost_pkg::STAT_REPLACED,
                                            handle: rd_entry.handle,
                                            rank: sost_pkg::to_rank(proc_idx_reg)};
                            rvalid_next = 1'b0;
                            state_next  = ST_FIN;
                        end
                    end else begin
                        if (shift_reg) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = proc_idx_reg - 1'b1;
                            ram_req.wdata = rd_entry;
                        end else if (key_eq) begin
                            res_next = '{status: sost_pkg::STAT_FOUND,
                                         handle: rd_entry.handle,
                                         rank: sost_pkg::to_rank(proc_idx_reg)};
                            if (is_remove) begin
                                shift_next = 1'b1;
                            end else begin
                                rvalid_next = 1'b0;
                                state_next  = ST_FIN;
                            end
                        end
                    end
                end else if (!issue) begin
                    state_next = ST_FIN;
                    if (is_insert) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cnt_reg[sost_pkg::IDX_W-1:0];
                        ram_req.wdata = shift_reg ? carry_reg : new_entry;
                        cnt_next      = cnt_reg + 1'b1;
                        if (!shift_reg) begin
                            res_next = '{status: sost_pkg::STAT_INSERTED, handle: '0,
                                         rank: sost_pkg::to_rank(
                                             cnt_reg[sost_pkg::IDX_W-1:0])};
                        end
                    end else if (shift_reg) begin
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        res_next = '{status: sost_pkg::STAT_NOT_FOUND, handle: '0, rank: '0};
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            shift_reg  <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
            shift_reg  <= shift_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= proc_idx_next;
        req_reg      <= req_next;
        carry_reg    <= carry_next;
        res_reg      <= res_next;
    end

endmodule

@@ rtl/sequence_ordered_segment_table_top.sv @@
// Top level of the sequence-ordered segment table with stream ports and result register.
// An operation reads the stored entries in order from the single entry RAM before its
// result reaches m_axis_tvalid; an insert into a full table skips the walk.
// One operation is in progress at a time; the next is accepted while a result waits.
// Transactions are accepted only in idle, once the last result is in the output register.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module sequence_ordered_segment_table_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Bits from low: seq_key[31:0], payload_handle[47:32].
    input  logic [sost_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // Bits from low: command[1:0].
    input  logic [sost_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Bits from low: found_handle[15:0], rank[20:16], zero fill [23:21].
    output logic [sost_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // Bits from low: status[2:0].
    output logic [sost_pkg::STAT_W-1:0]    m_axis_tuser
);

    sost_pkg::req_t                 req;
    sost_pkg::ram_req_t             ram_req;
    logic [sost_pkg::ENTRY_W-1:0]   ram_rdata;
    logic                           out_free;
    logic                           res_valid;
    sost_pkg::result_t              res;
    logic                           m_valid_reg, m_valid_next;
    sost_pkg::result_t              m_res_reg, m_res_next;

    assign req = '{cmd: s_axis_tuser,
                   key: s_axis_tdata[sost_pkg::KEY_W-1:0],
                   handle: s_axis_tdata[sost_pkg::S_DATA_W-1:sost_pkg::KEY_W]};

    sost_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    sost_ram #(
        .WIDTH (sost_pkg::ENTRY_W),
        .DEPTH (sost_pkg::DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {(sost_pkg::M_DATA_W - sost_pkg::RANK_W - sost_pkg::HDL_W)'(0),
                            m_res_reg.rank, m_res_reg.handle};

endmodule

@@ rtl/sost_checker.sv @@
// Port-level assertions for the segment table top level, bound to it.
module sost_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sost_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [sost_pkg::STAT_W-1:0]   m_axis_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= sost_pkg::STAT_FULL)
        else $error("status out of range");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == sost_pkg::STAT_NOT_FOUND
            || m_axis_tuser == sost_pkg::STAT_FULL) |-> m_axis_tdata == '0)
        else $error("miss or full result carries data");

    a_new_no_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == sost_pkg::STAT_INSERTED
            |-> m_axis_tdata[sost_pkg::HDL_W-1:0] == '0)
        else $error("new insert reports a handle");

endmodule

bind sequence_ordered_segment_table_top sost_checker u_sost_checker (.*);

@@ tb/sequence_ordered_segment_table_top_tb.sv @@
// Self-checking testbench for the sequence-ordered segment table with stream handshakes.
`timescale 1ns / 1ps

module sequence_ordered_segment_table_top_tb;
    import sost_pkg::*;

    localparam logic [CMD_W-1:0] CMD_FIND_ALIAS = 2'd3;
    localparam int DRAIN_CYCLES = 2 * (DEPTH + 3);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    logic [KEY_W-1:0]      seg_keys [DEPTH];
    logic [HDL_W-1:0]      seg_handles [DEPTH];
    int                    seg_count;
    result_t               expected_results [$];
    int                    mismatch_count = 0;
    int unsigned           burst_left = 0;
    int unsigned           idle_gap = 0;
    int unsigned           rx_mode = 0;
    int unsigned           rx_mode_left = 0;
    int unsigned           rx_tick = 0;

    sequence_ordered_segment_table_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit seq_after(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] diff;
        diff = a - b;
        return (diff != '0) && (diff[KEY_W-1] == 1'b0);
    endfunction

    function automatic bit key_present(logic [KEY_W-1:0] key);
        for (int i = 0; i < seg_count; i++) begin
            if (seg_keys[i] == key) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one command to the shadow table and returns the result it must produce.
    function automatic result_t predict_segment_op(logic [CMD_W-1:0] cmd,
                                                   logic [KEY_W-1:0] key,
                                                   logic [HDL_W-1:0] hdl);
        result_t res;
        int      pos;
        res = '0;
        pos = 0;
        if (cmd == CMD_INSERT) begin
            if (seg_count >= DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                while (pos < seg_count && !seq_after(seg_keys[pos], key)
                       && seg_keys[pos] != key) begin
                    pos++;
                end
                if (pos < seg_count && seg_keys[pos] == key) begin
                    res.status = STAT_REPLACED;
                    res.handle = seg_handles[pos];
                    seg_handles[pos] = hdl;
                end else begin
                    for (int j = seg_count; j > pos; j--) begin
                        seg_keys[j]    = seg_keys[j-1];
                        seg_handles[j] = seg_handles[j-1];
                    end
                    seg_keys[pos]    = key;
                    seg_handles[pos] = hdl;
                    seg_count++;
                    res.status = STAT_INSERTED;
                end
                res.rank = pos[RANK_W-1:0];
            end
        end else begin
            while (pos < seg_count && seg_keys[pos] != key) begin
                pos++;
            end
            if (pos < seg_count) begin
                res.status = STAT_FOUND;
                res.handle = seg_handles[pos];
                res.rank   = pos[RANK_W-1:0];
                if (cmd == CMD_REMOVE) begin
                    for (int j = pos; j < seg_count - 1; j++) begin
                        seg_keys[j]    = seg_keys[j+1];
                        seg_handles[j] = seg_handles[j+1];
                    end
                    seg_count--;
                end
            end else begin
                res.status = STAT_NOT_FOUND;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // Sends one transaction in bursts with random gaps, then records its expected result.
    task automatic send_segment_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [HDL_W-1:0] hdl);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        if (idle_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle_gap) @(posedge aclk);
            idle_gap = 0;
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hdl, key};
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        expected_results.push_back(predict_segment_op(cmd, key, hdl));
    endtask

    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= (rx_tick % 7) >= 3;
            end
            default: begin
                m_axis_tready <= (rx_tick % 9) == 0;
            end
        endcase
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result status", 32'(m_axis_tuser), '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser != want.status) begin
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                end
                if (m_axis_tdata[15:0] != want.handle) begin
                    report_mismatch("found_handle", 32'(m_axis_tdata[15:0]),
                                    32'(want.handle));
                end
                if (m_axis_tdata[20:16] != want.rank) begin
                    report_mismatch("rank", 32'(m_axis_tdata[20:16]), 32'(want.rank));
                end
            end
        end
    end

    task automatic test_empty_table();
        send_segment_op(CMD_FIND, 32'd5, 16'h1234);
        send_segment_op(CMD_REMOVE, 32'd5, 16'h0000);
        send_segment_op(CMD_FIND_ALIAS, 32'd5, 16'hFFFF);
        send_segment_op(CMD_INSERT, 32'd5, 16'h0000);
        send_segment_op(CMD_INSERT, 32'd5, 16'hFFFF);
        send_segment_op(CMD_FIND, 32'd5, 16'h0000);
    endtask

    task automatic test_key_extremes();
        send_segment_op(CMD_INSERT, 32'hFFFF_FFFF, 16'h0001);
        send_segment_op(CMD_INSERT, 32'h0000_0000, 16'h0002);
        send_segment_op(CMD_INSERT, 32'h8000_0005, 16'h0003);
        send_segment_op(CMD_INSERT, 32'h7FFF_FFFF, 16'hA5A5);
        send_segment_op(CMD_INSERT, 32'h8000_0000, 16'h5A5A);
        send_segment_op(CMD_FIND_ALIAS, 32'h8000_0000, 16'h0000);
        send_segment_op(CMD_FIND, 32'h1234_5678, 16'h0000);
        send_segment_op(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_segment_op(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_segment_op(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);
        send_segment_op(CMD_FIND, 32'h8000_0005, 16'h0000);
    endtask

    task automatic test_fill_and_overflow();
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] key;
        int               step;
        base = $urandom;
        step = 0;
        while (seg_count < DEPTH) begin
            key = base - 32'(step * 3);
            step++;
            if (!key_present(key)) begin
                send_segment_op(CMD_INSERT, key, 16'($urandom));
            end
        end
        send_segment_op(CMD_INSERT, base + 32'd1, 16'($urandom));
        send_segment_op(CMD_INSERT, seg_keys[DEPTH/2], 16'($urandom));
        send_segment_op(CMD_FIND, seg_keys[DEPTH-1], 16'($urandom));
        send_segment_op(CMD_REMOVE, seg_keys[0], 16'($urandom));
        send_segment_op(CMD_INSERT, base + 32'd1, 16'($urandom));
        send_segment_op(CMD_INSERT, base + 32'd2, 16'($urandom));
        send_segment_op(CMD_REMOVE, seg_keys[DEPTH-1], 16'($urandom));
        while (seg_count > 0) begin
            send_segment_op(CMD_REMOVE, seg_keys[$urandom_range(0, seg_count - 1)],
                            16'($urandom));
        end
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned      done;
        int unsigned      round_len;
        int unsigned      mix;
        int unsigned      r;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] spread;
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
        done = 0;
        while (done < n_items) begin
            mix = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: base = 32'hFFFF_FFF0;
                1: base = 32'h7FFF_FFF0;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: spread = 32'h0000_001F;
                1: spread = 32'h0000_0FFF;
                2: spread = 32'h7FFF_FFFF;
                default: spread = 32'hFFFF_FFFF;
            endcase
            round_len = $urandom_range(40, 120);
            for (int n = 0; n < round_len && done < n_items; n++) begin
                r = $urandom_range(0, 99);
                if (mix == 0) begin
                    cmd = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_FIND :
                          (r < 95) ? CMD_REMOVE : CMD_FIND_ALIAS;
                end else if (mix == 1) begin
                    cmd = (r < 20) ? CMD_INSERT : (r < 35) ? CMD_FIND :
                          (r < 95) ? CMD_REMOVE : CMD_FIND_ALIAS;
                end else begin
                    cmd = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_FIND :
                          (r < 95) ? CMD_REMOVE : CMD_FIND_ALIAS;
                end
                r = $urandom_range(0, 99);
                if (r < 45 && seg_count > 0) begin
                    key = seg_keys[$urandom_range(0, seg_count - 1)];
                end else if (r < 55) begin
                    key = (base ^ 32'h8000_0000) + ($urandom & 32'h3);
                end else if (r < 60) begin
                    key = $urandom;
                    cmd = CMD_W'($urandom_range(0, 3));
                end else begin
                    key = base + ($urandom & spread);
                end
                send_segment_op(cmd, key, 16'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        seg_count = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_key_extremes();
        test_fill_and_overflow();
        test_random_traffic(1650);
        test_fill_and_overflow();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(25_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
